// ===== src/cht_pkg.sv =====
// Shared types and constants of the coalesced hash table.
package cht_pkg;

  localparam int unsigned KEY_W      = 32;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned POS_W      = 9;
  localparam int unsigned CFG_W      = 9;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned HOME_RESET = 220;

  typedef enum logic [1:0] {
    ST_FREE = 2'd0,
    ST_LINK = 2'd1,
    ST_TAIL = 2'd2
  } slot_st_e;

  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_GET  = 2'd1,
    OP_DEL  = 2'd2,
    OP_SCAN = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RES_OK   = 2'd0,
    RES_MISS = 2'd1,
    RES_FULL = 2'd2
  } res_e;

  // Write and start strobes from the controller to the datapath.
  typedef struct packed {
    logic meta_we;
    logic kv_we;
    logic mod_start;
  } cht_cmd_t;

endpackage

// ===== src/cht_mod.sv =====
// Iterative key modulo home-count unit, one quotient bit per cycle.
module cht_mod #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [cht_pkg::KEY_W-1:0]         dividend_i,
  input  logic [$clog2(CAPACITY):0]         divisor_i,
  output logic                              done_o,
  output logic [$clog2(CAPACITY)-1:0]       rem_o
);
  import cht_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CW    = IDX_W + 1;
  localparam int unsigned CNT_W = $clog2(KEY_W);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CW-1:0]    rem_q;
  logic [CW-1:0]    rem_d;
  logic [CW-1:0]    div_q;
  logic [KEY_W-1:0] dvd_q;
  logic [CW:0]      trial;

  always_comb begin
    trial = {rem_q, dvd_q[KEY_W-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = CW'(trial - {1'b0, div_q});
    end else begin
      rem_d = CW'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(KEY_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= dvd_q << 1;
    end
  end

  assign done_o = done_q;
  // The remainder is below the divisor, which never exceeds the slot count.
  assign rem_o  = rem_q[IDX_W-1:0];

endmodule

// ===== src/cht_store.sv =====
// Datapath: slot status/link memory, key/value memory and the hash unit.
module cht_store #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  cht_pkg::cht_cmd_t                           cmd_i,
  input  logic [$clog2(CAPACITY)-1:0]                 waddr_i,
  input  logic [$clog2(CAPACITY)-1:0]                 raddr_i,
  input  logic [$clog2(CAPACITY)+1:0]                 meta_wdata_i,
  input  logic [cht_pkg::KEY_W+cht_pkg::VAL_W-1:0]    kv_wdata_i,
  input  logic [cht_pkg::KEY_W-1:0]                   mod_key_i,
  input  logic [$clog2(CAPACITY):0]                   divisor_i,
  output logic [$clog2(CAPACITY)+1:0]                 meta_rdata_o,
  output logic [cht_pkg::KEY_W+cht_pkg::VAL_W-1:0]    kv_rdata_o,
  output logic                                        mod_done_o,
  output logic [$clog2(CAPACITY)-1:0]                 mod_rem_o
);
  import cht_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned MW    = IDX_W + 2;
  localparam int unsigned KVW   = KEY_W + VAL_W;

  logic [MW-1:0]  meta_mem [CAPACITY];
  logic [KVW-1:0] kv_mem   [CAPACITY];
  logic [MW-1:0]  meta_rd_q;
  logic [KVW-1:0] kv_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.meta_we) begin
      meta_mem[waddr_i] <= meta_wdata_i;
    end
    meta_rd_q <= meta_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.kv_we) begin
      kv_mem[waddr_i] <= kv_wdata_i;
    end
    kv_rd_q <= kv_mem[raddr_i];
  end

  assign meta_rdata_o = meta_rd_q;
  assign kv_rdata_o   = kv_rd_q;

  cht_mod #(
    .CAPACITY(CAPACITY)
  ) u_mod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.mod_start),
    .dividend_i(mod_key_i),
    .divisor_i (divisor_i),
    .done_o    (mod_done_o),
    .rem_o     (mod_rem_o)
  );

endmodule

// ===== src/cht_ctrl.sv =====
// Controller: sequences chain walks, free-slot search, re-placement and scans.
module cht_ctrl #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_we_i,
  input  logic [cht_pkg::CFG_W-1:0]                   cfg_wdata_i,
  input  logic                                        in_valid_i,
  output logic                                        in_ready_o,
  input  logic [1:0]                                  in_kind_i,
  input  logic [cht_pkg::KEY_W-1:0]                   in_key_i,
  input  logic [cht_pkg::VAL_W-1:0]                   in_value_i,
  input  logic [cht_pkg::POS_W-1:0]                   in_pos_i,
  output logic                                        out_valid_o,
  input  logic                                        out_ready_i,
  output logic [cht_pkg::STAT_W-1:0]                  out_status_o,
  output logic [cht_pkg::VAL_W-1:0]                   out_value_o,
  output logic [cht_pkg::KEY_W-1:0]                   out_key_o,
  output logic [cht_pkg::POS_W-1:0]                   out_handle_o,
  output logic [cht_pkg::POS_W-1:0]                   out_total_o,
  output cht_pkg::cht_cmd_t                           cmd_o,
  output logic [$clog2(CAPACITY)-1:0]                 waddr_o,
  output logic [$clog2(CAPACITY)-1:0]                 raddr_o,
  output logic [$clog2(CAPACITY)+1:0]                 meta_wdata_o,
  output logic [cht_pkg::KEY_W+cht_pkg::VAL_W-1:0]    kv_wdata_o,
  output logic [cht_pkg::KEY_W-1:0]                   mod_key_o,
  output logic [$clog2(CAPACITY):0]                   divisor_o,
  input  logic [$clog2(CAPACITY)+1:0]                 meta_rdata_i,
  input  logic [cht_pkg::KEY_W+cht_pkg::VAL_W-1:0]    kv_rdata_i,
  input  logic                                        mod_done_i,
  input  logic [$clog2(CAPACITY)-1:0]                 mod_rem_i
);
  import cht_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CW    = IDX_W + 1;
  localparam int unsigned SW    = IDX_W + 2;
  localparam int unsigned MW    = IDX_W + 2;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_HASH, S_WRD, S_WCHK, S_FRD, S_FCHK, S_PLINK, S_PTAIL,
    S_DPREV, S_DFREE, S_RP, S_RPCHK, S_RPHASH, S_RPHRD, S_RPHCHK, S_RPFREE,
    S_RPTAIL, S_SRD, S_SCHK, S_DONE
  } state_e;

  state_e             state_q;
  logic [IDX_W-1:0]   clr_q;
  logic [CFG_W-1:0]   home_q;
  logic [CW-1:0]      hc;
  op_e                kind_q;
  logic [KEY_W-1:0]   key_q;
  logic [VAL_W-1:0]   val_q;
  logic [IDX_W-1:0]   e_q;
  logic [IDX_W-1:0]   prev_q;
  logic               has_prev_q;
  logic [IDX_W-1:0]   at_q;
  logic [IDX_W-1:0]   f_q;
  logic [IDX_W-1:0]   orig_link_q;
  logic               orig_is_link_q;
  logic [SW-1:0]      steps_q;
  logic [SW-1:0]      iter_q;
  logic [IDX_W-1:0]   i_q;
  logic [IDX_W-1:0]   cur_q;
  logic [IDX_W-1:0]   r_q;
  logic               last_q;
  logic [KEY_W-1:0]   ckey_q;
  logic [VAL_W-1:0]   cval_q;
  logic [IDX_W:0]     cnt_q;
  res_e               res_status_q;
  logic [VAL_W-1:0]   res_value_q;
  logic [KEY_W-1:0]   res_key_q;
  logic [POS_W-1:0]   res_hnd_q;
  logic               out_valid_q;
  logic [STAT_W-1:0]  out_status_q;
  logic [VAL_W-1:0]   out_value_q;
  logic [KEY_W-1:0]   out_key_q;
  logic [POS_W-1:0]   out_handle_q;
  logic [POS_W-1:0]   out_total_q;

  logic [1:0]         md_st;
  logic [IDX_W-1:0]   md_link;
  logic [KEY_W-1:0]   kd_key;
  logic [VAL_W-1:0]   kd_val;
  logic               w_home_free;
  logic               w_broken;
  logic               w_found;
  logic               w_end;
  logic               rp_follow;
  logic               accept;

  function automatic logic [MW-1:0] meta_word(slot_st_e st, logic [IDX_W-1:0] lnk);
    return {st, lnk};
  endfunction

  assign md_st   = meta_rdata_i[MW-1 -: 2];
  assign md_link = meta_rdata_i[IDX_W-1:0];
  assign kd_key  = kv_rdata_i[KEY_W+VAL_W-1:VAL_W];
  assign kd_val  = kv_rdata_i[VAL_W-1:0];

  // A register value of zero or above the slot count selects all slots as home.
  always_comb begin
    if (home_q == '0 || 32'(home_q) > CAPACITY) begin
      hc = CW'(CAPACITY);
    end else begin
      hc = CW'(home_q);
    end
  end
  assign divisor_o = hc;

  assign accept     = (state_q == S_IDLE) && in_valid_i;
  assign in_ready_o = (state_q == S_IDLE);

  // Chain walk decode on the slot read back in S_WCHK.
  assign w_home_free = (steps_q == '0) && (md_st == ST_FREE);
  assign w_broken    = !w_home_free && ((steps_q > SW'(CAPACITY)) || (md_st == ST_FREE));
  assign w_found     = !w_home_free && !w_broken && (kd_key == key_q);
  assign w_end       = !w_home_free && !w_broken && !w_found && (md_st == ST_TAIL);
  assign rp_follow   = (md_st == ST_LINK) && (steps_q < SW'(CAPACITY));

  always_comb begin
    cmd_o        = '0;
    waddr_o      = e_q;
    raddr_o      = e_q;
    meta_wdata_o = meta_word(ST_FREE, '0);
    kv_wdata_o   = {key_q, val_q};
    mod_key_o    = kd_key;
    case (state_q)
      S_CLR: begin
        cmd_o.meta_we = 1'b1;
        waddr_o       = clr_q;
      end
      S_IDLE: begin
        mod_key_o       = in_key_i;
        cmd_o.mod_start = in_valid_i && (op_e'(in_kind_i) != OP_SCAN);
      end
      S_WCHK: begin
        if (w_found && kind_q == OP_PUT) begin
          cmd_o.kv_we = 1'b1;
        end else if (w_home_free && kind_q == OP_PUT) begin
          cmd_o.meta_we = 1'b1;
          cmd_o.kv_we   = 1'b1;
          meta_wdata_o  = meta_word(ST_TAIL, '0);
        end
      end
      S_FRD: raddr_o = f_q;
      S_PLINK: begin
        cmd_o.meta_we = 1'b1;
        waddr_o       = at_q;
        meta_wdata_o  = meta_word(ST_LINK, f_q);
      end
      S_PTAIL: begin
        cmd_o.meta_we = 1'b1;
        cmd_o.kv_we   = 1'b1;
        waddr_o       = f_q;
        meta_wdata_o  = meta_word(ST_TAIL, '0);
      end
      S_DPREV: begin
        cmd_o.meta_we = has_prev_q;
        waddr_o       = prev_q;
        meta_wdata_o  = meta_word(ST_TAIL, '0);
      end
      S_DFREE: begin
        cmd_o.meta_we = 1'b1;
        waddr_o       = at_q;
      end
      S_RP: raddr_o = i_q;
      S_RPCHK: cmd_o.mod_start = (md_st != ST_FREE);
      S_RPHRD: raddr_o = r_q;
      S_RPHCHK: begin
        waddr_o = r_q;
        if (steps_q == '0 && md_st == ST_FREE) begin
          cmd_o.meta_we = 1'b1;
          cmd_o.kv_we   = 1'b1;
          meta_wdata_o  = meta_word(ST_TAIL, '0);
          kv_wdata_o    = {ckey_q, cval_q};
        end else if (!rp_follow && md_st == ST_TAIL) begin
          cmd_o.meta_we = 1'b1;
          meta_wdata_o  = meta_word(ST_LINK, cur_q);
        end
      end
      S_RPFREE: begin
        cmd_o.meta_we = 1'b1;
        waddr_o       = cur_q;
      end
      S_RPTAIL: begin
        cmd_o.meta_we = 1'b1;
        waddr_o       = cur_q;
        meta_wdata_o  = meta_word(ST_TAIL, '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      home_q      <= CFG_W'(HOME_RESET);
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      has_prev_q  <= 1'b0;
      steps_q     <= '0;
      iter_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        home_q <= cfg_wdata_i;
      end
      // S_DONE reloads the output register itself.
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == IDX_W'(CAPACITY - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            kind_q       <= op_e'(in_kind_i);
            key_q        <= in_key_i;
            val_q        <= in_value_i;
            res_status_q <= RES_OK;
            res_value_q  <= '0;
            res_key_q    <= '0;
            res_hnd_q    <= '0;
            if (op_e'(in_kind_i) != OP_SCAN) begin
              state_q <= S_HASH;
            end else if (32'(in_pos_i) >= CAPACITY) begin
              res_status_q <= RES_MISS;
              state_q      <= S_DONE;
            end else begin
              e_q     <= IDX_W'(in_pos_i);
              state_q <= S_SRD;
            end
          end
        end
        S_HASH: begin
          if (mod_done_i) begin
            e_q        <= mod_rem_i;
            steps_q    <= '0;
            has_prev_q <= 1'b0;
            state_q    <= S_WRD;
          end
        end
        S_WRD: state_q <= S_WCHK;
        S_WCHK: begin
          if (w_home_free) begin
            if (kind_q == OP_PUT) begin
              cnt_q <= cnt_q + 1'b1;
            end else begin
              res_status_q <= RES_MISS;
            end
            state_q <= S_DONE;
          end else if (w_broken) begin
            res_status_q <= (kind_q == OP_PUT) ? RES_FULL : RES_MISS;
            state_q      <= S_DONE;
          end else if (w_found) begin
            at_q           <= e_q;
            orig_link_q    <= md_link;
            orig_is_link_q <= (md_st == ST_LINK);
            if (kind_q == OP_GET) begin
              res_value_q <= kd_val;
            end
            state_q <= (kind_q == OP_DEL) ? S_DPREV : S_DONE;
          end else if (w_end) begin
            if (kind_q == OP_PUT) begin
              at_q    <= e_q;
              f_q     <= IDX_W'(CAPACITY - 1);
              state_q <= S_FRD;
            end else begin
              res_status_q <= RES_MISS;
              state_q      <= S_DONE;
            end
          end else begin
            prev_q     <= e_q;
            has_prev_q <= 1'b1;
            e_q        <= md_link;
            steps_q    <= steps_q + 1'b1;
            state_q    <= S_WRD;
          end
        end
        // Free-slot search runs from the top slot downward.
        S_FRD: state_q <= S_FCHK;
        S_FCHK: begin
          if (md_st == ST_FREE) begin
            state_q <= S_PLINK;
          end else if (f_q == '0) begin
            res_status_q <= RES_FULL;
            state_q      <= S_DONE;
          end else begin
            f_q     <= f_q - 1'b1;
            state_q <= S_FRD;
          end
        end
        S_PLINK: state_q <= S_PTAIL;
        S_PTAIL: begin
          cnt_q   <= cnt_q + 1'b1;
          state_q <= S_DONE;
        end
        S_DPREV: state_q <= S_DFREE;
        S_DFREE: begin
          if (cnt_q != '0) begin
            cnt_q <= cnt_q - 1'b1;
          end
          if (orig_is_link_q) begin
            i_q     <= orig_link_q;
            iter_q  <= '0;
            last_q  <= 1'b0;
            state_q <= S_RP;
          end else begin
            state_q <= S_DONE;
          end
        end
        // Re-placement: each former successor moves home or joins its chain tail.
        S_RP: begin
          if (iter_q > SW'(CAPACITY)) begin
            state_q <= S_DONE;
          end else begin
            iter_q  <= iter_q + 1'b1;
            cur_q   <= i_q;
            state_q <= S_RPCHK;
          end
        end
        S_RPCHK: begin
          if (md_st == ST_FREE) begin
            state_q <= S_DONE;
          end else begin
            if (md_st == ST_TAIL) begin
              last_q <= 1'b1;
            end else begin
              i_q <= md_link;
            end
            ckey_q  <= kd_key;
            cval_q  <= kd_val;
            state_q <= S_RPHASH;
          end
        end
        S_RPHASH: begin
          if (mod_done_i) begin
            r_q     <= mod_rem_i;
            steps_q <= '0;
            state_q <= S_RPHRD;
          end
        end
        S_RPHRD: state_q <= S_RPHCHK;
        S_RPHCHK: begin
          if (steps_q == '0 && md_st == ST_FREE) begin
            state_q <= S_RPFREE;
          end else if (rp_follow) begin
            r_q     <= md_link;
            steps_q <= steps_q + 1'b1;
            state_q <= S_RPHRD;
          end else if (md_st == ST_TAIL) begin
            state_q <= S_RPTAIL;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_RPFREE, S_RPTAIL: state_q <= last_q ? S_DONE : S_RP;
        S_SRD: state_q <= S_SCHK;
        S_SCHK: begin
          if (md_st != ST_FREE) begin
            res_key_q   <= kd_key;
            res_value_q <= kd_val;
            res_hnd_q   <= POS_W'(32'(e_q) + 32'd1);
            state_q     <= S_DONE;
          end else if (e_q == IDX_W'(CAPACITY - 1)) begin
            res_status_q <= RES_MISS;
            state_q      <= S_DONE;
          end else begin
            e_q     <= e_q + 1'b1;
            state_q <= S_SRD;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_value_q  <= res_value_q;
            out_key_q    <= res_key_q;
            out_handle_q <= res_hnd_q;
            out_total_q  <= POS_W'(cnt_q);
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;
  assign out_key_o    = out_key_q;
  assign out_handle_o = out_handle_q;
  assign out_total_o  = out_total_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= CAPACITY)
    else $error("entry count above slot count");

  a_mod_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done_i |-> (state_q == S_HASH || state_q == S_RPHASH))
    else $error("hash result arrived while not waiting for it");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("accepted transaction did not start");

endmodule

// ===== src/coalesced_hash_table.sv =====
// Top level of the coalesced hash table with cellar.
//
// Requests enter on the s_axis channel: tuser carries the operation (put,
// get, delete, scan) and tdata the key, value and scan position. One result
// leaves on m_axis for every request. The user writes the home-slot count on
// cfg_we_i / cfg_wdata_i only while no request is in flight (not enforced).
//
// Operations run one at a time. Put, get and delete first compute the home
// slot with a bit-serial modulo unit, then walk the chain through the
// registered slot memories. Put past the tail of a chain searches for a
// free slot from the top. Delete re-places the rest of the chain; each
// moved entry costs one more hash, then moves to its home slot if that is
// free or else walks to its chain tail. Scan reads slots upward from the
// given position until it finds an occupied one or reaches the top slot.
// After reset the slot status memory is cleared, one slot per cycle;
// s_axis_tready stays low meanwhile. A result waits in the output register
// while m_axis_tready is low; the next request is still accepted and runs,
// then holds its result until the register frees up.
module coalesced_hash_table #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [31:0] key, [63:32] value, [72:64] position, [79:73] zero
  input  logic [79:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [33:2] value_out, [65:34] key_out, [74:66] handle,
  // [83:75] entry_total, [87:84] zero
  output logic [87:0] m_axis_tdata
);
  import cht_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);

  cht_cmd_t                  cmd;
  logic [IDX_W-1:0]          waddr;
  logic [IDX_W-1:0]          raddr;
  logic [IDX_W+1:0]          meta_wdata;
  logic [IDX_W+1:0]          meta_rdata;
  logic [KEY_W+VAL_W-1:0]    kv_wdata;
  logic [KEY_W+VAL_W-1:0]    kv_rdata;
  logic [KEY_W-1:0]          mod_key;
  logic [IDX_W:0]            divisor;
  logic                      mod_done;
  logic [IDX_W-1:0]          mod_rem;
  logic [STAT_W-1:0]         out_status;
  logic [VAL_W-1:0]          out_value;
  logic [KEY_W-1:0]          out_key;
  logic [POS_W-1:0]          out_handle;
  logic [POS_W-1:0]          out_total;

  cht_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_kind_i   (s_axis_tuser),
    .in_key_i    (s_axis_tdata[31:0]),
    .in_value_i  (s_axis_tdata[63:32]),
    .in_pos_i    (s_axis_tdata[72:64]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_status_o(out_status),
    .out_value_o (out_value),
    .out_key_o   (out_key),
    .out_handle_o(out_handle),
    .out_total_o (out_total),
    .cmd_o       (cmd),
    .waddr_o     (waddr),
    .raddr_o     (raddr),
    .meta_wdata_o(meta_wdata),
    .kv_wdata_o  (kv_wdata),
    .mod_key_o   (mod_key),
    .divisor_o   (divisor),
    .meta_rdata_i(meta_rdata),
    .kv_rdata_i  (kv_rdata),
    .mod_done_i  (mod_done),
    .mod_rem_i   (mod_rem)
  );

  cht_store #(
    .CAPACITY(CAPACITY)
  ) u_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .waddr_i     (waddr),
    .raddr_i     (raddr),
    .meta_wdata_i(meta_wdata),
    .kv_wdata_i  (kv_wdata),
    .mod_key_i   (mod_key),
    .divisor_i   (divisor),
    .meta_rdata_o(meta_rdata),
    .kv_rdata_o  (kv_rdata),
    .mod_done_o  (mod_done),
    .mod_rem_o   (mod_rem)
  );

  assign m_axis_tdata = {4'b0, out_total, out_handle, out_key, out_value, out_status};

endmodule
